[src/srrw_pkg.sv]
// Shared types and constants for the selective-repeat receive window.
package srrw_pkg;

    localparam int SEQ_SPACE_DEF = 256;
    localparam int WINDOW_DEF    = 31;
    localparam int MAX_LEN_DEF   = 512;

    localparam logic [1:0] KIND_DELIVER = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_NACK    = 2'd2;

    typedef struct packed {
        logic        packet_ok;
        logic        truncated;
        logic [7:0]  seq_number;
        logic [9:0]  payload_length;
        logic [31:0] send_time;
        logic [31:0] now_ms;
    } pkt_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  seq_field;
        logic [9:0]  deliver_length;
        logic [4:0]  window_free;
        logic [31:0] elapsed;
        logic        done_res;
        logic        last;
    } rsp_word_t;

endpackage

[src/selective_repeat_receive_window.sv]
// Selective-repeat receive window: top level with sequencer and slot store.
// A bad word, or any word once finished, is dropped at accept; an out-of-window word holds
// the input through the reduce and check states and is then dropped. A NACK passes straight
// to the answer state, a non-head ACK through the reduce, check and answer states.
// In a slide, each delivered slot passes the slide, read (slot RAM read) and output states,
// waiting there for rsp_ready, then the answer state sends the closing ACK; at most WINDOW slots per word.
// One word is in flight at a time; pkt_ready is high only when idle.
// Reset (rst_n low, async) clears the fill flags at once; no clearing pass.
module selective_repeat_receive_window #(
    parameter int SEQ_SPACE = srrw_pkg::SEQ_SPACE_DEF,
    parameter int WINDOW    = srrw_pkg::WINDOW_DEF,
    parameter int MAX_LEN   = srrw_pkg::MAX_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    output logic                pkt_ready,
    input  srrw_pkg::pkt_word_t pkt,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output srrw_pkg::rsp_word_t rsp
);

    import srrw_pkg::*;

    localparam int SEQ_W = $clog2(SEQ_SPACE);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_REDUCE = 7'b0000010,
        ST_CHECK  = 7'b0000100,
        ST_ANSWER = 7'b0001000,
        ST_SLIDE  = 7'b0010000,
        ST_READ   = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [7:0]           seq_reg, seq_next;
    logic [9:0]           len_reg, len_next;
    logic [31:0]          stamp_reg, stamp_next;
    logic [31:0]          now_reg, now_next;
    logic [1:0]           kind_reg, kind_next;
    logic [SEQ_W-1:0]     ws_reg, ws_next;
    logic [SEQ_W-1:0]     slot_reg, slot_next;
    logic [4:0]           free_reg, free_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [7:0]           lio_reg, lio_next;
    logic                 fin_reg, fin_next;
    logic [SEQ_SPACE-1:0] filled_reg, filled_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_word_t            rsp_reg, rsp_next;

    logic [31:0]          sub_a, sub_b;
    logic [32:0]          sub_y;
    logic                 borrow;
    logic [SEQ_W:0]       offset;
    logic [SEQ_W-1:0]     seq_idx;
    logic [9:0]           len_sat;

    logic                 ram_we, ram_re;
    logic [41:0]          ram_rd;

    assign sub_y  = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow = sub_y[32];
    assign offset = borrow ? sub_y[SEQ_W:0] + (SEQ_W+1)'(SEQ_SPACE) : sub_y[SEQ_W:0];
    assign seq_idx = seq_reg[SEQ_W-1:0];
    assign len_sat = ({1'b0, pkt.payload_length} > 11'(MAX_LEN))
                   ? 10'(MAX_LEN) : pkt.payload_length;

    srrw_ram #(
        .WIDTH (42),
        .DEPTH (SEQ_SPACE)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (seq_idx),
        .wr_data ({len_reg, stamp_reg}),
        .rd_en   (ram_re),
        .rd_addr (ws_reg),
        .rd_data (ram_rd)
    );

    always_comb
    begin
        case (state_reg)
            ST_REDUCE:
            begin
                sub_a = {24'd0, seq_reg};
                sub_b = 32'(SEQ_SPACE);
            end
            ST_CHECK:
            begin
                sub_a = {24'd0, seq_reg};
                sub_b = 32'(ws_reg);
            end
            default:
            begin
                sub_a = now_reg;
                sub_b = stamp_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        seq_next       = seq_reg;
        len_next       = len_reg;
        stamp_next     = stamp_reg;
        now_next       = now_reg;
        kind_next      = kind_reg;
        ws_next        = ws_reg;
        slot_next      = slot_reg;
        free_next      = free_reg;
        cnt_next       = cnt_reg;
        lio_next       = lio_reg;
        fin_next       = fin_reg;
        filled_next    = filled_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (pkt_valid && !fin_reg && pkt.packet_ok)
                begin
                    seq_next   = pkt.seq_number;
                    len_next   = len_sat;
                    stamp_next = pkt.send_time;
                    now_next   = pkt.now_ms;
                    kind_next  = KIND_NACK;
                    state_next = pkt.truncated ? ST_ANSWER : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (!borrow)
                begin
                    seq_next = sub_y[7:0];
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (32'(offset) >= 32'(WINDOW))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_we = 1'b1;
                    filled_next[seq_idx] = 1'b1;
                    if (!filled_reg[seq_idx] && free_reg != 5'd0)
                    begin
                        free_next = free_reg - 5'd1;
                    end
                    kind_next  = KIND_ACK;
                    cnt_next   = 5'd0;
                    state_next = (seq_idx == ws_reg) ? ST_SLIDE : ST_ANSWER;
                end
            end
            ST_ANSWER:
            begin
                fin_next                = fin_reg | (len_reg == 10'd0);
                rsp_next.kind           = kind_reg;
                rsp_next.seq_field      = lio_reg;
                rsp_next.deliver_length = 10'd0;
                rsp_next.window_free    = free_reg;
                rsp_next.elapsed        = sub_y[31:0];
                rsp_next.done_res       = fin_reg | (len_reg == 10'd0);
                rsp_next.last           = 1'b1;
                rsp_valid_next          = 1'b1;
                state_next              = ST_OUT;
            end
            ST_SLIDE:
            begin
                if (cnt_reg == 5'(WINDOW) || !filled_reg[ws_reg])
                begin
                    kind_next  = KIND_ACK;
                    state_next = ST_ANSWER;
                end
                else
                begin
                    ram_re = 1'b1;
                    filled_next[ws_reg] = 1'b0;
                    if (free_reg < 5'(WINDOW))
                    begin
                        free_next = free_reg + 5'd1;
                    end
                    slot_next  = ws_reg;
                    ws_next    = (ws_reg == SEQ_W'(SEQ_SPACE - 1)) ? '0 : ws_reg + 1'b1;
                    lio_next   = 8'(ws_reg);
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                len_next                = ram_rd[41:32];
                stamp_next              = ram_rd[31:0];
                rsp_next.kind           = KIND_DELIVER;
                rsp_next.seq_field      = 8'(slot_reg);
                rsp_next.deliver_length = ram_rd[41:32];
                rsp_next.window_free    = free_reg;
                rsp_next.elapsed        = 32'd0;
                rsp_next.done_res       = fin_reg;
                rsp_next.last           = 1'b0;
                rsp_valid_next          = 1'b1;
                state_next              = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp_ready)
                begin
                    rsp_valid_next = 1'b0;
                    state_next     = rsp_reg.last ? ST_IDLE : ST_SLIDE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ws_reg        <= '0;
            free_reg      <= 5'(WINDOW);
            lio_reg       <= 8'hFF;
            fin_reg       <= 1'b0;
            filled_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= 5'd0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            free_reg      <= free_next;
            lio_reg       <= lio_next;
            fin_reg       <= fin_next;
            filled_reg    <= filled_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg   <= seq_next;
        len_reg   <= len_next;
        stamp_reg <= stamp_next;
        now_reg   <= now_next;
        kind_reg  <= kind_next;
        slot_reg  <= slot_next;
        rsp_reg   <= rsp_next;
    end

    assign pkt_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[src/srrw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module srrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/srrw_checker.sv]
// Port-level checks for the selective-repeat receive window, bound to the top.
module srrw_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                pkt_valid,
    input logic                pkt_ready,
    input srrw_pkg::pkt_word_t pkt,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input srrw_pkg::rsp_word_t rsp
);

    import srrw_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result word changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(pkt_ready && rsp_valid))
        else $error("input taken while a result is pending");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.last == (rsp.kind != KIND_DELIVER)))
        else $error("last flag disagrees with result kind");

    a_deliver_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind == KIND_DELIVER |-> rsp.elapsed == 32'd0 && !rsp.done_res)
        else $error("deliver word carries ack fields");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && rsp.done_res |=> !rsp_valid)
        else $error("result after transfer finished");

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (.*);
